/* hw/rtl/rrts_pkg.sv */
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants of the round-robin thread scheduler
// Thread and semaphore counts, command codes, word layouts and the layout of
// one thread entry in the scheduler state memory.
// ----------------------------------------------------------------------------
package rrts_pkg;

  // Ring size and semaphore count.
  localparam int THREADS    = 4;
  localparam int SEMAPHORES = 16;

  // Derived widths.
  localparam int TID_W = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int CNT_W = $clog2(THREADS + 1);

  // Fixed field widths of the stream words.
  localparam int MODE_W   = 3;
  localparam int SEMID_W  = 4;
  localparam int VAL_W    = 32;
  localparam int TICKS_W  = 32;
  localparam int OTID_W   = 2;
  localparam int IN_DW    = 72;
  localparam int OUT_DW   = 40;

  // Command codes.
  typedef logic [MODE_W-1:0] mode_t;
  localparam mode_t MODE_TICK   = 3'd0;
  localparam mode_t MODE_YIELD  = 3'd1;
  localparam mode_t MODE_SLEEP  = 3'd2;
  localparam mode_t MODE_WAIT   = 3'd3;
  localparam mode_t MODE_SIGNAL = 3'd4;

  // One thread entry of the state memory.
  typedef struct packed {
    logic [TICKS_W-1:0] sleep_left;
    logic               blocked;
    logic [SEMID_W-1:0] blocked_sem;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Next thread in ring order.
  function automatic logic [TID_W-1:0] ring_next(input logic [TID_W-1:0] t);
    ring_next = (t == TID_W'(THREADS - 1)) ? '0 : t + 1'b1;
  endfunction

endpackage

/* hw/rtl/rrts_ram.sv */
// ----------------------------------------------------------------------------
// rrts_ram: generic simple dual-port RAM
// One write port and one read port per cycle, read data registered.
// ----------------------------------------------------------------------------
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

/* hw/rtl/round_robin_thread_scheduler.sv */
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler: hardware round-robin scheduler
// Tick, yield, sleep, semaphore wait and semaphore signal commands over a
// fixed ring of threads, with per-thread sleep counts and blocking.
// ----------------------------------------------------------------------------
// One command word is taken at a time and answered by one result word. The
// per-thread state lives in a small RAM that is swept once per command, one
// thread a cycle in ring order starting after the running thread, and the
// result word is assembled in a result register at the end of the sweep
// and moved into the output register once that register is free. A new
// command is taken as soon as the previous one has been finished, even while
// its result still waits in the output register. After reset thread zero runs
// and every thread is ready. When a switch finds no ready thread, the running
// thread is kept; when a signal finds no waiter, the state is kept; in both
// cases a flag is raised.
module round_robin_thread_scheduler (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // mode[2:0], sem_id[6:3], sem_value[38:7], sleep_ticks[70:39], zero[71]
  input  logic [rrts_pkg::IN_DW-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // running[1:0], switched[2], none_ready[3], sem_value_out[35:4],
  // woke_valid[36], woke_thread[38:37], no_waiter[39]
  output logic [rrts_pkg::OUT_DW-1:0] out_tdata
);

  import rrts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_HOLD  = 3'b100
  } state_t;

  // Input word fields.
  mode_t              in_mode;
  logic [SEMID_W-1:0] in_sem_id;
  logic [VAL_W-1:0]   in_sem_value;
  logic [TICKS_W-1:0] in_sleep_ticks;

  assign in_mode        = in_tdata[2:0];
  assign in_sem_id      = in_tdata[6:3];
  assign in_sem_value   = in_tdata[38:7];
  assign in_sleep_ticks = in_tdata[70:39];

  state_t             state_r, state_nxt;
  logic [TID_W-1:0]   run_r, run_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TID_W-1:0]   addr_r, addr_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic [TID_W-1:0]   rd_tid_r, rd_tid_nxt;
  logic               rd_vld_r;
  logic [THREADS-1:0] vld_r;

  // Command captured at acceptance.
  mode_t              mode_r;
  logic [SEMID_W-1:0] sem_r;
  logic [TICKS_W-1:0] ticks_r;
  logic [VAL_W-1:0]   vout_r;
  logic               want_r, wait_act_r, sig_act_r;

  // Sweep progress.
  logic               fnd_r, fnd_nxt;
  logic [TID_W-1:0]   tgt_r, tgt_nxt;
  logic               woke_r, woke_nxt;
  logic [TID_W-1:0]   wtid_r, wtid_nxt;

  // Result and output registers.
  logic [OUT_DW-1:0]  res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0]  out_data_r, out_data_nxt;

  // Accept-time decode.
  logic               accept, sem_ok, sig_val_np;
  logic [VAL_W-1:0]   vdec, vinc;

  assign accept = in_tvalid && in_tready;
  assign sem_ok = (32'(in_sem_id) < 32'(SEMAPHORES));
  assign vdec   = in_sem_value - 1'b1;
  assign vinc   = in_sem_value + 1'b1;
  assign sig_val_np = vinc[VAL_W-1] || (vinc == '0);

  // State RAM ports.
  logic [ENTRY_W-1:0] ram_rdata;
  logic               ram_we;
  entry_t             ent, ent_new;
  logic               is_run, ent_ready, last;

  rrts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (THREADS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rd_tid_r),
    .wdata (ent_new),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  // Entries never written read as the reset value.
  assign ent    = rd_vld_r ? entry_t'(ram_rdata) : '0;
  assign is_run = (rd_tid_r == run_r);
  assign last   = rd_pend_r && (cnt_r == CNT_W'(THREADS));

  // Read-modify-write of the entry that arrives this cycle.
  always_comb begin
    ent_new = ent;
    ram_we  = 1'b0;
    woke_nxt = woke_r;
    wtid_nxt = wtid_r;
    if (rd_pend_r) begin
      unique case (mode_r)
        MODE_TICK: begin
          if (!is_run && ent.sleep_left != '0) begin
            ent_new.sleep_left = ent.sleep_left - 1'b1;
            ram_we = 1'b1;
          end
        end
        MODE_SLEEP: begin
          if (is_run) begin
            ent_new.sleep_left = ticks_r;
            ram_we = 1'b1;
          end
        end
        MODE_WAIT: begin
          if (wait_act_r && is_run) begin
            ent_new.blocked     = 1'b1;
            ent_new.blocked_sem = sem_r;
            ram_we = 1'b1;
          end
        end
        MODE_SIGNAL: begin
          if (sig_act_r && !woke_r && ent.blocked && ent.blocked_sem == sem_r) begin
            ent_new.blocked     = 1'b0;
            ent_new.blocked_sem = '0;
            ram_we   = 1'b1;
            woke_nxt = 1'b1;
            wtid_nxt = rd_tid_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // First ready thread in ring order is the switch target.
  assign ent_ready = (ent_new.sleep_left == '0) && !ent_new.blocked;

  always_comb begin
    fnd_nxt = fnd_r;
    tgt_nxt = tgt_r;
    if (rd_pend_r && !fnd_r && ent_ready) begin
      fnd_nxt = 1'b1;
      tgt_nxt = rd_tid_r;
    end
  end

  // Sequencer and result assembly.
  always_comb begin
    logic sw;
    logic [OTID_W-1:0] run_o;
    sw            = want_r && fnd_nxt;
    state_nxt     = state_r;
    run_nxt       = run_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    rd_pend_nxt   = 1'b0;
    rd_tid_nxt    = rd_tid_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    run_o         = OTID_W'(sw ? tgt_nxt : run_r);
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SWEEP;
          cnt_nxt   = '0;
          addr_nxt  = ring_next(run_r);
        end
      end
      ST_SWEEP: begin
        if (cnt_r != CNT_W'(THREADS)) begin
          rd_pend_nxt = 1'b1;
          rd_tid_nxt  = addr_r;
          addr_nxt    = ring_next(addr_r);
          cnt_nxt     = cnt_r + 1'b1;
        end
        if (last) begin
          if (sw) begin
            run_nxt = tgt_nxt;
          end
          res_nxt = {
            sig_act_r && !woke_nxt,
            woke_nxt ? OTID_W'(wtid_nxt) : OTID_W'(0),
            woke_nxt,
            vout_r,
            want_r && !fnd_nxt,
            sw,
            run_o
          };
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      run_r       <= '0;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      fnd_r       <= 1'b0;
      woke_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      cnt_r       <= cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        vld_r[rd_tid_r] <= 1'b1;
      end
      if (accept) begin
        fnd_r  <= 1'b0;
        woke_r <= 1'b0;
      end else begin
        fnd_r  <= fnd_nxt;
        woke_r <= woke_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    rd_tid_r   <= rd_tid_nxt;
    rd_vld_r   <= vld_r[addr_r];
    tgt_r      <= tgt_nxt;
    wtid_r     <= wtid_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    if (accept) begin
      mode_r     <= in_mode;
      sem_r      <= in_sem_id;
      ticks_r    <= in_sleep_ticks;
      wait_act_r <= (in_mode == MODE_WAIT) && sem_ok && vdec[VAL_W-1];
      sig_act_r  <= (in_mode == MODE_SIGNAL) && sem_ok && sig_val_np;
      want_r     <= (in_mode == MODE_TICK) || (in_mode == MODE_YIELD) ||
                    (in_mode == MODE_SLEEP) ||
                    ((in_mode == MODE_WAIT) && sem_ok && vdec[VAL_W-1]);
      if ((in_mode == MODE_WAIT) && sem_ok) begin
        vout_r <= vdec;
      end else if ((in_mode == MODE_SIGNAL) && sem_ok) begin
        vout_r <= vinc;
      end else begin
        vout_r <= in_sem_value;
      end
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
